/* rtl/lcnc_pkg.sv */
// shared types, constants and helpers of the luhn card number classifier
package lcnc_pkg;

  localparam int CARD_W     = 63;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;
  localparam int CLASS_W    = 2;
  localparam int COUNT_W    = 5;
  localparam int DIGIT_W    = 4;

  // the card number is divided by ten one 16-bit slice per cycle, top slice first
  localparam int CHUNK_W     = 16;
  localparam int NCHUNK      = (CARD_W + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W       = NCHUNK * CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(NCHUNK);
  localparam logic [CHUNK_IDX_W-1:0] CHUNK_TOP = CHUNK_IDX_W'(NCHUNK - 1);

  localparam logic [DIGIT_W-1:0] RADIX = 4'd10;

  // digit counts of the recognized formats
  localparam logic [COUNT_W-1:0] LEN_SHORT = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_MID   = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_LONG  = 5'd16;

  // leading digit values used by the prefix checks
  localparam logic [DIGIT_W-1:0] DIG_1 = 4'd1;
  localparam logic [DIGIT_W-1:0] DIG_3 = 4'd3;
  localparam logic [DIGIT_W-1:0] DIG_4 = 4'd4;
  localparam logic [DIGIT_W-1:0] DIG_5 = 4'd5;
  localparam logic [DIGIT_W-1:0] DIG_7 = 4'd7;

  typedef enum logic [CLASS_W-1:0] {
    CLS_NONE    = 2'd0,
    CLS_LEAD4   = 2'd1,
    CLS_LEAD3X  = 2'd2,
    CLS_LEAD5X  = 2'd3
  } issuer_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic                ok;
    logic                too_long;
    logic [COUNT_W-1:0]  count;
    logic [DIGIT_W-1:0]  lead;
    logic [DIGIT_W-1:0]  second;
  } summary_t;

  // luhn contribution of one digit; odd positions are doubled and digit-summed
  function automatic logic [DIGIT_W-1:0] luhn_term(input logic [DIGIT_W-1:0] d,
                                                   input logic odd);
    logic [DIGIT_W:0] dbl;
    dbl = {d, 1'b0};
    if (!odd) begin
      luhn_term = d;
    end else if (dbl >= {1'b0, RADIX}) begin
      luhn_term = DIGIT_W'(dbl - 5'd9);
    end else begin
      luhn_term = dbl[DIGIT_W-1:0];
    end
  endfunction

endpackage

/* rtl/lcnc_div10.sv */
// divide-by-ten step: one 16-bit slice of long division, reciprocal per byte
module lcnc_div10
  import lcnc_pkg::*;
(
  input  logic [DIGIT_W-1:0] rem_in,
  input  logic [CHUNK_W-1:0] slice,
  output logic [CHUNK_W-1:0] quotient,
  output logic [DIGIT_W-1:0] remainder
);

  localparam int NBYTES = CHUNK_W / 8;
  // floor(v * 6554 / 2^16) equals floor(v / 10) for every partial value here
  localparam logic [24:0] RECIP = 25'd6554;

  // rem_in is the remainder of the slices above and is always below ten
  always_comb begin
    logic [11:0]        v;
    logic [24:0]        prod;
    logic [7:0]         qc;
    logic [11:0]        rem12;
    logic [DIGIT_W-1:0] r;
    quotient = '0;
    r        = rem_in;
    for (int i = NBYTES - 1; i >= 0; i--) begin
      v     = {r, slice[i*8 +: 8]};
      prod  = {13'd0, v} * RECIP;
      qc    = prod[16 +: 8];
      rem12 = v - ({4'd0, qc} * 12'd10);
      r     = rem12[DIGIT_W-1:0];
      quotient[i*8 +: 8] = qc;
    end
    remainder = r;
  end

endmodule

/* rtl/lcnc_classify.sv */
// issuer classification from digit count, leading digits and check outcome
module lcnc_classify
  import lcnc_pkg::*;
(
  input  summary_t             summary,
  output logic [CLASS_W-1:0]   issuer_class
);

  issuer_t cls;

  always_comb begin
    priority if (!summary.ok || summary.too_long) begin
      cls = CLS_NONE;
    end else if (summary.count == LEN_SHORT && summary.lead == DIG_4) begin
      cls = CLS_LEAD4;
    end else if (summary.count == LEN_MID && summary.lead == DIG_3 &&
                 (summary.second == DIG_4 || summary.second == DIG_7)) begin
      cls = CLS_LEAD3X;
    end else if (summary.count == LEN_LONG && summary.lead == DIG_4) begin
      cls = CLS_LEAD4;
    end else if (summary.count == LEN_LONG && summary.lead == DIG_5 &&
                 summary.second >= DIG_1 && summary.second <= DIG_5) begin
      cls = CLS_LEAD5X;
    end else begin
      cls = CLS_NONE;
    end
  end

  assign issuer_class = cls;

endmodule

/* rtl/luhn_card_number_classifier_core.sv */
// luhn card number classifier top level: digit sequencer around a shared divide-by-ten
//
// channel  dir  handshake                 payload
// in       in   in_tvalid / in_tready     in_tdata: card_number[62:0]
// out      out  out_tvalid / out_tready   out_tdata: luhn_ok, digit_count; out_tuser: class
//
// each digit takes one pass over the four slices: the shared step divides one 16-bit slice by ten per cycle
// a request is taken only while the sequencer is idle, so the next request waits until
// the result of the previous one has been loaded into the output register
// synchronous active-low reset clears the sequencer and the output valid
// a stalled result holds in the output register while the next request runs
module luhn_card_number_classifier_core
  import lcnc_pkg::*;
#(
  parameter int MAX_DIGITS = 19
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [62:0] card_number, [63] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] luhn_ok, [5:1] digit_count, [7:6] zero
  output logic [CLASS_W-1:0]    out_tuser   // [1:0] issuer_class
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

  state_t                  state_r, state_nxt;
  logic [PAD_W-1:0]        rest_r, rest_nxt;
  logic [CHUNK_IDX_W-1:0]  chunk_r, chunk_nxt;
  logic [DIGIT_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [DIGIT_W-1:0]      sum_r, sum_nxt;
  logic [DIGIT_W-1:0]      lead_r, lead_nxt;
  logic [DIGIT_W-1:0]      second_r, second_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CLASS_W-1:0]      out_class_r, out_class_nxt;
  logic                    out_ok_r, out_ok_nxt;
  logic [COUNT_W-1:0]      out_count_r, out_count_nxt;

  logic [CHUNK_W-1:0]  slice;
  logic [CHUNK_W-1:0]  quo;
  logic [DIGIT_W-1:0]  digit;
  logic [DIGIT_W-1:0]  term;
  logic [DIGIT_W:0]    sum_wide;
  logic                more;
  logic                in_fire;
  logic                out_free;
  summary_t            summary;
  logic [CLASS_W-1:0]  cls;

  assign slice = rest_r[chunk_r*CHUNK_W +: CHUNK_W];

  lcnc_div10 u_div10 (
    .rem_in    (rem_r),
    .slice     (slice),
    .quotient  (quo),
    .remainder (digit)
  );

  assign summary.ok       = (sum_r == '0);
  assign summary.too_long = (rest_r != '0);
  assign summary.count    = COUNT_W'(n_r);
  assign summary.lead     = lead_r;
  assign summary.second   = second_r;

  lcnc_classify u_classify (
    .summary      (summary),
    .issuer_class (cls)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign more      = (rest_r != '0) && (n_r < CNT_MAX);

  // running sum is kept modulo ten
  assign term     = luhn_term(digit, n_r[0]);
  assign sum_wide = {1'b0, sum_r} + {1'b0, term};

  always_comb begin
    state_nxt     = state_r;
    rest_nxt      = rest_r;
    chunk_nxt     = chunk_r;
    rem_nxt       = rem_r;
    n_nxt         = n_r;
    sum_nxt       = sum_r;
    lead_nxt      = lead_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_class_nxt = out_class_r;
    out_ok_nxt    = out_ok_r;
    out_count_nxt = out_count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          rest_nxt  = {{(PAD_W - CARD_W){1'b0}}, in_tdata[CARD_W-1:0]};
          chunk_nxt = CHUNK_TOP;
          rem_nxt   = '0;
          n_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // the stop test is made only between digits, on the full quotient
        if (chunk_r == CHUNK_TOP && !more) begin
          state_nxt = ST_DONE;
        end else begin
          // quotient slices replace the dividend in place, top slice first
          rest_nxt[chunk_r*CHUNK_W +: CHUNK_W] = quo;
          if (chunk_r == '0) begin
            chunk_nxt  = CHUNK_TOP;
            rem_nxt    = '0;
            n_nxt      = n_r + 1'b1;
            lead_nxt   = digit;
            second_nxt = lead_r;
            if (sum_wide >= {1'b0, RADIX}) begin
              sum_nxt = DIGIT_W'(sum_wide - {1'b0, RADIX});
            end else begin
              sum_nxt = sum_wide[DIGIT_W-1:0];
            end
          end else begin
            chunk_nxt = chunk_r - 1'b1;
            rem_nxt   = digit;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_class_nxt = cls;
          out_ok_nxt    = summary.ok;
          out_count_nxt = summary.count;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r      <= rest_nxt;
    chunk_r     <= chunk_nxt;
    rem_r       <= rem_nxt;
    n_r         <= n_nxt;
    sum_r       <= sum_nxt;
    lead_r      <= lead_nxt;
    second_r    <= second_nxt;
    out_class_r <= out_class_nxt;
    out_ok_r    <= out_ok_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - COUNT_W - 1){1'b0}}, out_count_r, out_ok_r};
  assign out_tuser  = out_class_r;

  // a new request starts with an empty digit count
  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_RUN) && (n_r == '0) && (sum_r == '0))
    else $error("digit sequencer did not start clean");

  // the digit loop never runs past its limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (n_r == CNT_MAX) |=> (state_r == ST_DONE))
    else $error("digit loop overran its limit");

  // running sum stays reduced modulo ten
  a_sum_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (sum_r < RADIX))
    else $error("luhn sum not reduced");

  // a recognized issuer implies a passed check and a valid length
  a_class_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != CLS_NONE) |->
      out_tdata[0] && (out_tdata[COUNT_W:1] == LEN_SHORT ||
                       out_tdata[COUNT_W:1] == LEN_MID ||
                       out_tdata[COUNT_W:1] == LEN_LONG))
    else $error("issuer class without passing check or valid length");

  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid_r && !out_tready |=> (state_r == ST_DONE))
    else $error("result overwrote a pending output");

endmodule
